// File: rtl/date_difference_in_days_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for date_difference_in_days
// Clocked on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_IN_DAYS_ASSERT_SVH
`define DATE_DIFFERENCE_IN_DAYS_ASSERT_SVH

// cond must hold at every edge outside reset
`define DDID_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold at the edge after ante
`define DDID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// cons must hold at the same edge as ante
`define DDID_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/ddid_pkg.sv
// ----------------------------------------------------------------------------
// ddid_pkg
// Types, constants and calendar functions for the date difference block.
// ----------------------------------------------------------------------------
package ddid_pkg;

	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned DAYS_W  = 21;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd1900;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 12'd2025;

	typedef enum logic [1:0] {
		STATUS_AHEAD   = 2'd0,
		STATUS_SAME    = 2'd1,
		STATUS_LATER   = 2'd2,
		STATUS_INVALID = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_MIN_YEAR = 1'b0,
		CFG_MAX_YEAR = 1'b1
	} cfg_index_t;

	// Reciprocal of 100 scaled by 2^19; exact floor for operands below 43690
	localparam logic [25:0] RECIP_100 = 26'd5243;

	function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
		logic [8:0] s;
		case (m)
			4'd1:    s = 9'd0;
			4'd2:    s = 9'd31;
			4'd3:    s = 9'd59;
			4'd4:    s = 9'd90;
			4'd5:    s = 9'd120;
			4'd6:    s = 9'd151;
			4'd7:    s = 9'd181;
			4'd8:    s = 9'd212;
			4'd9:    s = 9'd243;
			4'd10:   s = 9'd273;
			4'd11:   s = 9'd304;
			4'd12:   s = 9'd334;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
	                                               input logic leap);
		logic [DAY_W-1:0] l;
		case (m)
			4'd2:                        l = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:     l = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7,
			4'd8, 4'd10, 4'd12:          l = 5'd31;
			default:                     l = 5'd0;
		endcase
		return l;
	endfunction

	function automatic logic [6:0] div100(input logic [12:0] x);
		logic [25:0] p;
		p = 26'(x) * RECIP_100;
		return p[25:19];
	endfunction

	// Full Gregorian rule
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [6:0]  q;
		logic [13:0] back;
		logic        cent;
		q    = div100({1'b0, y});
		back = 14'(q) * 14'd100;
		cent = (back == 14'(y));
		return (y[1:0] == 2'b00) && (!cent || (q[1:0] == 2'b00));
	endfunction

	// Days since 1 January of year 0; month assumed 1 to 12
	function automatic logic [DAYS_W-1:0] day_number(input logic [MONTH_W-1:0] m,
	                                                 input logic [DAY_W-1:0] d,
	                                                 input logic [YEAR_W-1:0] y,
	                                                 input logic leap);
		logic [12:0]        c4;
		logic [6:0]         c100;
		logic [6:0]         c400x4;
		logic [10:0]        leaps;
		logic [DAYS_W-1:0]  n;
		c4     = (13'(y) + 13'd3) >> 2;
		c100   = div100(13'(y) + 13'd99);
		c400x4 = div100(13'(y) + 13'd399);
		leaps  = 11'(c4) - 11'(c100) + 11'(c400x4[6:2]);
		n = DAYS_W'(y) * 21'd365 + DAYS_W'(leaps) + DAYS_W'(month_start(m))
		    + DAYS_W'(d) - 21'd1;
		if (m > 4'd2 && leap)
			n = n + 21'd1;
		return n;
	endfunction

endpackage

// File: rtl/date_difference_in_days.sv
// A request is held in the input register, its result in the result register.
// Throughput: one request per cycle while res_stall is low; while a result
// waits to be read, a request is taken only into an empty input register.
// Reset clears both valid flags and loads the year bounds to 1900 and 2025.
// ----------------------------------------------------------------------------
// date_difference_in_days
// Validates two calendar dates, reports their order and how many days the second is ahead.
// ----------------------------------------------------------------------------
module date_difference_in_days (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  ddid_pkg::cfg_index_t    cfg_index,
	input  logic [11:0]             cfg_data,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [3:0]              first_month,
	input  logic [4:0]              first_day,
	input  logic [11:0]             first_year,
	input  logic [3:0]              second_month,
	input  logic [4:0]              second_day,
	input  logic [11:0]             second_year,
	output logic                    res_valid,
	input  logic                    res_stall,
	output ddid_pkg::status_t       status,
	output logic [20:0]             days_ahead
);
	import ddid_pkg::*;

	logic [YEAR_W-1:0]  min_year_q, max_year_q;

	logic               valid_s1;
	logic [MONTH_W-1:0] m1_s1, m2_s1;
	logic [DAY_W-1:0]   d1_s1, d2_s1;
	logic [YEAR_W-1:0]  y1_s1, y2_s1;

	logic               valid_s2;
	status_t            status_s2;
	logic [DAYS_W-1:0]  days_s2;

	logic               load_s2, load_s1;
	logic               leap1, leap2, ok1, ok2;
	logic [DAYS_W-1:0]  n1, n2;
	logic [DAYS_W:0]    diff;
	status_t            status_d;
	logic [DAYS_W-1:0]  days_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_YEAR: min_year_q <= cfg_data;
				CFG_MAX_YEAR: max_year_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Result register moves when empty or read; input register when empty or when it can drain
	assign load_s2   = !valid_s2 || !res_stall;
	assign load_s1   = !valid_s1 || load_s2;
	assign req_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			m1_s1 <= first_month;
			d1_s1 <= first_day;
			y1_s1 <= first_year;
			m2_s1 <= second_month;
			d2_s1 <= second_day;
			y2_s1 <= second_year;
		end
	end

	always_comb begin
		leap1 = is_leap(y1_s1);
		leap2 = is_leap(y2_s1);
		ok1 = (m1_s1 >= 4'd1) && (m1_s1 <= 4'd12) && (y1_s1 >= min_year_q)
		      && (y1_s1 <= max_year_q) && (d1_s1 != 5'd0)
		      && (d1_s1 <= month_len(m1_s1, leap1));
		ok2 = (m2_s1 >= 4'd1) && (m2_s1 <= 4'd12) && (y2_s1 >= min_year_q)
		      && (y2_s1 <= max_year_q) && (d2_s1 != 5'd0)
		      && (d2_s1 <= month_len(m2_s1, leap2));
		n1   = day_number(m1_s1, d1_s1, y1_s1, leap1);
		n2   = day_number(m2_s1, d2_s1, y2_s1, leap2);
		diff = {1'b0, n2} - {1'b0, n1};
		days_d = '0;
		if (!(ok1 && ok2)) begin
			status_d = STATUS_INVALID;
		end else if (diff == '0) begin
			status_d = STATUS_SAME;
		end else if (diff[DAYS_W]) begin
			status_d = STATUS_LATER;
		end else begin
			status_d = STATUS_AHEAD;
			days_d   = diff[DAYS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			status_s2 <= status_d;
			days_s2   <= days_d;
		end
	end

	assign res_valid  = valid_s2;
	assign status     = status_s2;
	assign days_ahead = days_s2;

endmodule

// File: rtl/ddid_checker.sv
// ----------------------------------------------------------------------------
// ddid_checker
// Port-level checks on date_difference_in_days, attached by bind.
// ----------------------------------------------------------------------------
`include "date_difference_in_days_assert.svh"

module ddid_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_stall,
	input  logic                    res_valid,
	input  logic                    res_stall,
	input  ddid_pkg::status_t       status,
	input  logic [20:0]             days_ahead
);
	import ddid_pkg::*;

	// day count is nonzero exactly when the second date is ahead
	`DDID_ASSERT_IMPL(a_days_zero, res_valid && status != STATUS_AHEAD, days_ahead == '0, "days_ahead set for non-ahead status")
	`DDID_ASSERT_IMPL(a_days_nonzero, res_valid && status == STATUS_AHEAD, days_ahead != '0, "ahead status with zero days")
	`DDID_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(status) && $stable(days_ahead), "stalled result changed")
	// a fresh result traces back to a request taken through the input register and then the result register
	`DDID_ASSERT_IMPL(a_latency, $rose(res_valid), $past(req_valid && !req_stall, 2), "result without matching request")

endmodule

bind date_difference_in_days ddid_checker u_ddid_checker (.*);

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for date_difference_in_days. Directed date pairs cover
// field extremes, leap rules and bound edges; random pairs are mostly valid
// dates inside the current year window. Each request is predicted when it is
// taken and the prediction is compared with the result in order.
// ----------------------------------------------------------------------------
module tb;
	import ddid_pkg::*;

	localparam int CLK_HALF          = 10;
	localparam int QUIET_LIMIT       = 1000;
	localparam int HOLD_OFF_CYCLES   = 64;
	localparam int ITEMS_PER_SETTING = 80;
	localparam int SETTINGS_COUNT    = 6;

	typedef struct packed {
		logic [3:0]  first_month;
		logic [4:0]  first_day;
		logic [11:0] first_year;
		logic [3:0]  second_month;
		logic [4:0]  second_day;
		logic [11:0] second_year;
	} date_pair_t;

	typedef struct packed {
		status_t     status;
		logic [20:0] days;
	} span_t;

	class date_span_checker;
		span_t       pending_spans[$];
		int unsigned min_year;
		int unsigned max_year;
		int          errors;

		function new();
			min_year = 1900;
			max_year = 2025;
			errors   = 0;
		endfunction

		task log_mismatch(input string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function bit leap_year(input int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		// month must be 1 to 12
		function int unsigned month_days(input int unsigned m, input int unsigned y);
			case (m)
				2:           return leap_year(y) ? 29 : 28;
				4, 6, 9, 11: return 30;
				default:     return 31;
			endcase
		endfunction

		function bit date_valid(input int unsigned m, input int unsigned d,
		                        input int unsigned y);
			if (m < 1 || m > 12)
				return 1'b0;
			if (y < min_year || y > max_year)
				return 1'b0;
			return d >= 1 && d <= month_days(m, y);
		endfunction

		// days since 1 Jan of year 0, proleptic calendar
		function int unsigned ordinal(input int unsigned m, input int unsigned d,
		                              input int unsigned y);
			int unsigned n;
			int unsigned k;
			n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d - 1;
			for (k = 1; k < m; k++)
				n += month_days(k, y);
			return n;
		endfunction

		function span_t predict_span(input date_pair_t p);
			span_t       s;
			int unsigned a;
			int unsigned b;
			s.status = STATUS_INVALID;
			s.days   = '0;
			if (!date_valid(p.first_month, p.first_day, p.first_year) ||
			    !date_valid(p.second_month, p.second_day, p.second_year))
				return s;
			a = ordinal(p.first_month, p.first_day, p.first_year);
			b = ordinal(p.second_month, p.second_day, p.second_year);
			if (a == b) begin
				s.status = STATUS_SAME;
			end else if (a > b) begin
				s.status = STATUS_LATER;
			end else begin
				s.status = STATUS_AHEAD;
				s.days   = 21'(b - a);
			end
			return s;
		endfunction

		function void note_request(input date_pair_t p);
			pending_spans.push_back(predict_span(p));
		endfunction

		task check_result(input status_t st, input logic [20:0] days);
			span_t want;
			if (pending_spans.size() == 0) begin
				log_mismatch($sformatf("unexpected result status %0d days %0d", st, days));
				return;
			end
			want = pending_spans.pop_front();
			if (st !== want.status)
				log_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			if (days !== want.days)
				log_mismatch($sformatf("days_ahead %0d, expected %0d", days, want.days));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	cfg_index_t  cfg_index;
	logic [11:0] cfg_data;
	logic        req_valid;
	logic        req_stall;
	logic [3:0]  first_month;
	logic [4:0]  first_day;
	logic [11:0] first_year;
	logic [3:0]  second_month;
	logic [4:0]  second_day;
	logic [11:0] second_year;
	logic        res_valid;
	logic        res_stall = 1'b0;
	status_t     status;
	logic [20:0] days_ahead;

	date_span_checker sb;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	bit hold_pending  = 1'b0;
	int quiet_cycles  = 0;

	date_difference_in_days DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.first_month  (first_month),
		.first_day    (first_day),
		.first_year   (first_year),
		.second_month (second_month),
		.second_day   (second_day),
		.second_year  (second_year),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.status       (status),
		.days_ahead   (days_ahead)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic date_pair_t pair_of(input int m1, input int d1, input int y1,
	                                       input int m2, input int d2, input int y2);
		date_pair_t p;
		p.first_month  = 4'(m1);
		p.first_day    = 5'(d1);
		p.first_year   = 12'(y1);
		p.second_month = 4'(m2);
		p.second_day   = 5'(d2);
		p.second_year  = 12'(y2);
		return p;
	endfunction

	// mostly valid dates inside the window, some identical or same-year pairs,
	// some with a broken second month, the rest raw noise
	function automatic date_pair_t random_pair();
		date_pair_t  p;
		int unsigned pick;
		p    = date_pair_t'({$urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 20 || sb.min_year > sb.max_year)
			return p;
		p.first_year  = 12'($urandom_range(sb.max_year, sb.min_year));
		p.first_month = 4'($urandom_range(12, 1));
		p.first_day   = 5'($urandom_range(sb.month_days(p.first_month, p.first_year), 1));
		if (pick < 35) begin
			p.second_month = p.first_month;
			p.second_day   = p.first_day;
			p.second_year  = p.first_year;
			return p;
		end
		if (pick < 55)
			p.second_year = p.first_year;
		else
			p.second_year = 12'($urandom_range(sb.max_year, sb.min_year));
		p.second_month = 4'($urandom_range(12, 1));
		p.second_day   = 5'($urandom_range(sb.month_days(p.second_month, p.second_year), 1));
		if (pick >= 92)
			p.second_month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
		return p;
	endfunction

	task automatic offer_request(input date_pair_t p);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		first_month  <= p.first_month;
		first_day    <= p.first_day;
		first_year   <= p.first_year;
		second_month <= p.second_month;
		second_day   <= p.second_day;
		second_year  <= p.second_year;
		req_valid    <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(p);
	endtask

	task automatic drain_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending_spans.size() != 0)
			@(posedge clk);
	endtask

	// only called with nothing in flight
	task automatic write_bounds(input int unsigned lo, input int unsigned hi);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_YEAR;
		cfg_data  <= 12'(lo);
		@(negedge clk);
		cfg_index <= CFG_MAX_YEAR;
		cfg_data  <= 12'(hi);
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.min_year = lo;
		sb.max_year = hi;
	endtask

	initial begin : result_sink
		int held;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
					res_stall <= 1'b1;
					@(negedge clk);
				end
			end
			res_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(status, days_ahead);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("date_difference_in_days verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned bound_lo[SETTINGS_COUNT];
		int unsigned bound_hi[SETTINGS_COUNT];
		int          n;
		sb           = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_MIN_YEAR;
		cfg_data     = '0;
		req_valid    = 1'b0;
		first_month  = '0;
		first_day    = '0;
		first_year   = '0;
		second_month = '0;
		second_day   = '0;
		second_year  = '0;
		bound_lo = '{0, 1900, 1999, 4095, 0, 1582};
		bound_hi = '{4095, 2025, 2001, 4095, 0, 2400};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct  = 27;
		sink_idle_pct = 60;
		// reset window 1900..2025
		offer_request(pair_of(2, 29, 1900, 3, 1, 1900));
		offer_request(pair_of(1, 1, 1899, 1, 1, 1900));
		offer_request(pair_of(1, 1, 1900, 12, 31, 2025));
		offer_request(pair_of(12, 31, 2025, 1, 1, 2026));
		offer_request(pair_of(2, 29, 2000, 2, 29, 2000));

		drain_results();
		write_bounds(0, 4095);
		offer_request(pair_of(2, 29, 0, 3, 1, 0));
		offer_request(pair_of(1, 1, 0, 12, 31, 4095));
		offer_request(pair_of(12, 31, 4095, 1, 1, 0));
		offer_request(pair_of(0, 1, 2000, 1, 1, 2000));
		offer_request(pair_of(13, 1, 2000, 1, 1, 2000));
		offer_request(pair_of(1, 1, 2000, 15, 31, 4095));
		offer_request(pair_of(1, 0, 2000, 1, 1, 2000));
		offer_request(pair_of(4, 31, 2001, 5, 1, 2001));
		offer_request(pair_of(1, 31, 2001, 5, 31, 2001));
		offer_request(pair_of(2, 29, 2100, 3, 1, 2100));
		offer_request(pair_of(2, 29, 2400, 2, 28, 2400));
		offer_request(pair_of(2, 28, 2023, 3, 1, 2023));

		// crossed bounds: nothing is valid
		drain_results();
		write_bounds(3000, 100);
		offer_request(pair_of(6, 15, 1000, 6, 16, 1000));
		offer_request(pair_of(1, 1, 100, 1, 1, 3000));

		for (n = 0; n < SETTINGS_COUNT; n++) begin
			drain_results();
			write_bounds(bound_lo[n], bound_hi[n]);
			@(posedge clk);
			case (n / 2)
				0: begin
					src_idle_pct  = 27;
					sink_idle_pct = 60;
				end
				1: begin
					src_idle_pct  = 60;
					sink_idle_pct = 27;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			// back-pressure while the sender keeps pushing
			if (n == 4)
				hold_pending = 1'b1;
			repeat (ITEMS_PER_SETTING)
				offer_request(random_pair());
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("date_difference_in_days verification clean");
		else
			$display("date_difference_in_days verification failed");
		$finish;
	end

endmodule
